// File: design/hsp_pkg.sv
// Shared types and constants for the humidity sensor poller core.
// Holds the transaction payload structs, command and event codes and register indexes.
// No dependencies.
package hsp_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned FrameWidth    = 48;
  localparam int unsigned TickWidth     = 16;

  localparam logic [6:0]  DeviceAddressReset     = 7'd56;
  localparam logic [15:0] WaitBeforeMeasureReset = 16'd1000;
  localparam logic [15:0] WaitBeforeReadReset    = 16'd80;
  localparam logic [7:0]  ExpectedStatusReset    = 8'd24;
  localparam logic [7:0]  TriggerCommandReset    = 8'd172;
  localparam logic [7:0]  TriggerArgFirstReset   = 8'd51;
  localparam logic [7:0]  TriggerArgSecondReset  = 8'd0;

  localparam logic ReqTick = 1'b0;
  localparam logic ReqBus  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EV_START_SENT    = 3'd0,
    EV_ADDR_WR_ACK   = 3'd1,
    EV_ADDR_RD_ACK   = 3'd2,
    EV_DATA_SENT_ACK = 3'd3,
    EV_RX_ACK        = 3'd4,
    EV_RX_NACK       = 3'd5,
    EV_OTHER         = 3'd6
  } bus_event_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DEVICE_ADDRESS      = 3'd0,
    CFG_WAIT_BEFORE_MEASURE = 3'd1,
    CFG_WAIT_BEFORE_READ    = 3'd2,
    CFG_EXPECTED_STATUS     = 3'd3,
    CFG_TRIGGER_COMMAND     = 3'd4,
    CFG_TRIGGER_ARG_FIRST   = 3'd5,
    CFG_TRIGGER_ARG_SECOND  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] wait_before_measure;
    logic [15:0] wait_before_read;
    logic [7:0]  expected_status;
    logic [7:0]  trigger_command;
    logic [7:0]  trigger_arg_first;
    logic [7:0]  trigger_arg_second;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] bus_event;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bus_cmd;
    logic [7:0]  tx_byte;
    logic        meas_valid;
    logic [19:0] humidity_raw;
    logic [19:0] temperature_raw;
    logic [7:0]  sensor_status;
  } out_item_t;

endpackage

// File: design/hsp_cfg_regs.sv
// Configuration register file for the humidity sensor poller core.
// Write-only registers with reset defaults; depends on hsp_pkg.
module hsp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hsp_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [hsp_pkg::CfgDataWidth-1:0]   cfg_data,
  output hsp_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address      <= hsp_pkg::DeviceAddressReset;
      cfg.wait_before_measure <= hsp_pkg::WaitBeforeMeasureReset;
      cfg.wait_before_read    <= hsp_pkg::WaitBeforeReadReset;
      cfg.expected_status     <= hsp_pkg::ExpectedStatusReset;
      cfg.trigger_command     <= hsp_pkg::TriggerCommandReset;
      cfg.trigger_arg_first   <= hsp_pkg::TriggerArgFirstReset;
      cfg.trigger_arg_second  <= hsp_pkg::TriggerArgSecondReset;
    end else if (cfg_we) begin
      case (cfg_index)
        hsp_pkg::CFG_DEVICE_ADDRESS:      cfg.device_address      <= cfg_data[6:0];
        hsp_pkg::CFG_WAIT_BEFORE_MEASURE: cfg.wait_before_measure <= cfg_data;
        hsp_pkg::CFG_WAIT_BEFORE_READ:    cfg.wait_before_read    <= cfg_data;
        hsp_pkg::CFG_EXPECTED_STATUS:     cfg.expected_status     <= cfg_data[7:0];
        hsp_pkg::CFG_TRIGGER_COMMAND:     cfg.trigger_command     <= cfg_data[7:0];
        hsp_pkg::CFG_TRIGGER_ARG_FIRST:   cfg.trigger_arg_first   <= cfg_data[7:0];
        hsp_pkg::CFG_TRIGGER_ARG_SECOND:  cfg.trigger_arg_second  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/hsp_seq.sv
// Measurement sequencer: phase flags, byte counter, tick counter and frame shifter.
// Computes one bus command per transaction in a single pass; depends on hsp_pkg.
module hsp_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  hsp_pkg::in_item_t  item,
  input  hsp_pkg::cfg_t      cfg,
  output hsp_pkg::out_item_t result
);

  logic        measure_pending, measure_pending_next;
  logic        read_pending, read_pending_next;
  logic        frame_done, frame_done_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [hsp_pkg::FrameWidth-1:0] frame_shift, frame_shift_next;
  logic [hsp_pkg::TickWidth-1:0]  elapsed_ticks, elapsed_ticks_next;
  logic [7:0]  last_sent_byte, last_sent_byte_next;

  logic [hsp_pkg::TickWidth-1:0]  ticks_inc;
  logic [hsp_pkg::FrameWidth-1:0] frame_shifted;

  assign ticks_inc = (elapsed_ticks == '1) ? elapsed_ticks
                                            : elapsed_ticks + hsp_pkg::TickWidth'(1);
  assign frame_shifted = {frame_shift[hsp_pkg::FrameWidth-9:0], item.rx_byte};

  always_comb begin
    measure_pending_next = measure_pending;
    read_pending_next    = read_pending;
    frame_done_next      = frame_done;
    byte_index_next      = byte_index;
    frame_shift_next     = frame_shift;
    elapsed_ticks_next   = elapsed_ticks;
    last_sent_byte_next  = last_sent_byte;
    result               = '0;

    if (item.req_type == hsp_pkg::ReqTick) begin
      elapsed_ticks_next = ticks_inc;
      if (measure_pending) begin
        if (ticks_inc > cfg.wait_before_measure) begin
          elapsed_ticks_next = '0;
          result.bus_cmd     = hsp_pkg::CMD_START;
        end
      end else if (read_pending) begin
        if (ticks_inc > cfg.wait_before_read) begin
          elapsed_ticks_next = '0;
          frame_shift_next   = '0;
          result.bus_cmd     = hsp_pkg::CMD_START;
        end
      end else if (frame_done) begin
        result.meas_valid      = 1'b1;
        result.humidity_raw    = frame_shift[39:20];
        result.temperature_raw = frame_shift[19:0];
        result.sensor_status   = frame_shift[47:40];
        elapsed_ticks_next     = '0;
        measure_pending_next   = 1'b1;
        read_pending_next      = 1'b0;
        frame_done_next        = 1'b0;
      end
    end else begin
      case (item.bus_event)
        hsp_pkg::EV_START_SENT: begin
          result.bus_cmd = hsp_pkg::CMD_TX;
          if (measure_pending) begin
            measure_pending_next = 1'b0;
            last_sent_byte_next  = {cfg.device_address, 1'b0};
          end else if (read_pending) begin
            read_pending_next   = 1'b0;
            last_sent_byte_next = {cfg.device_address, 1'b1};
          end
          result.tx_byte = last_sent_byte_next;
        end
        hsp_pkg::EV_ADDR_WR_ACK: begin
          byte_index_next     = 3'd1;
          last_sent_byte_next = cfg.trigger_command;
          result.bus_cmd      = hsp_pkg::CMD_TX;
          result.tx_byte      = cfg.trigger_command;
        end
        hsp_pkg::EV_ADDR_RD_ACK: begin
          result.bus_cmd = hsp_pkg::CMD_RX_ACK;
        end
        hsp_pkg::EV_DATA_SENT_ACK: begin
          if (byte_index == 3'd1) begin
            byte_index_next     = 3'd2;
            last_sent_byte_next = cfg.trigger_arg_first;
            result.bus_cmd      = hsp_pkg::CMD_TX;
            result.tx_byte      = cfg.trigger_arg_first;
          end else if (byte_index == 3'd2) begin
            byte_index_next     = 3'd3;
            last_sent_byte_next = cfg.trigger_arg_second;
            result.bus_cmd      = hsp_pkg::CMD_TX;
            result.tx_byte      = cfg.trigger_arg_second;
          end else if (byte_index == 3'd3) begin
            // Trigger written; wait before reading the frame.
            byte_index_next    = 3'd0;
            elapsed_ticks_next = '0;
            read_pending_next  = 1'b1;
            result.bus_cmd     = hsp_pkg::CMD_STOP;
          end
        end
        hsp_pkg::EV_RX_ACK: begin
          if (byte_index == 3'd0) begin
            if (item.rx_byte != cfg.expected_status) begin
              // Sensor still busy or in a bad state: retry the read later.
              read_pending_next  = 1'b1;
              elapsed_ticks_next = '0;
              result.bus_cmd     = hsp_pkg::CMD_STOP;
            end else begin
              byte_index_next  = 3'd1;
              frame_shift_next = {{(hsp_pkg::FrameWidth-8){1'b0}}, item.rx_byte};
              result.bus_cmd   = hsp_pkg::CMD_RX_ACK;
            end
          end else if (byte_index inside {[3'd1:3'd3]}) begin
            byte_index_next  = byte_index + 3'd1;
            frame_shift_next = frame_shifted;
            result.bus_cmd   = hsp_pkg::CMD_RX_ACK;
          end else if (byte_index == 3'd4) begin
            byte_index_next  = 3'd5;
            frame_shift_next = frame_shifted;
            result.bus_cmd   = hsp_pkg::CMD_RX_NACK;
          end
        end
        hsp_pkg::EV_RX_NACK: begin
          byte_index_next  = 3'd0;
          frame_shift_next = frame_shifted;
          frame_done_next  = 1'b1;
          result.bus_cmd   = hsp_pkg::CMD_STOP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_pending <= 1'b1;
      read_pending    <= 1'b0;
      frame_done      <= 1'b0;
      byte_index      <= '0;
      frame_shift     <= '0;
      elapsed_ticks   <= '0;
      last_sent_byte  <= '0;
    end else if (accept) begin
      measure_pending <= measure_pending_next;
      read_pending    <= read_pending_next;
      frame_done      <= frame_done_next;
      byte_index      <= byte_index_next;
      frame_shift     <= frame_shift_next;
      elapsed_ticks   <= elapsed_ticks_next;
      last_sent_byte  <= last_sent_byte_next;
    end
  end

  // The byte counter only ever walks through the six frame positions.
  assert property (@(posedge clk) disable iff (rst) byte_index <= 3'd5)
    else $error("hsp_seq: byte_index out of range");

  // Presenting a measurement returns the cycle to the measurement wait.
  assert property (@(posedge clk) disable iff (rst)
    accept && result.meas_valid |=> measure_pending && elapsed_ticks == '0 && !frame_done)
    else $error("hsp_seq: cycle did not restart after presenting a measurement");

  // A transmit byte is only carried by a transmit command.
  assert property (@(posedge clk) disable iff (rst)
    result.tx_byte != 8'd0 |-> result.bus_cmd == hsp_pkg::CMD_TX)
    else $error("hsp_seq: tx_byte set without a transmit command");

endmodule

// File: design/hsp_out_buf.sv
// Two-entry result buffer between the sequencer and the output channel.
// Lets the core take a new transaction while a result waits; depends on hsp_pkg.
module hsp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsp_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output hsp_pkg::out_item_t out_data
);

  hsp_pkg::out_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("hsp_out_buf: occupancy overflow");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("hsp_out_buf: push into a full buffer");

  // Pointers differ exactly when one entry is held.
  assert property (@(posedge clk) disable iff (rst) (wr_ptr != rd_ptr) == (count == 2'd1))
    else $error("hsp_out_buf: pointers disagree with occupancy");

endmodule

// File: design/humidity_sensor_i2c_poller_core.sv
// Top level of the humidity sensor poller core.
// Instantiates hsp_cfg_regs, hsp_seq and hsp_out_buf; depends on hsp_pkg.
//
// The core takes one transaction per clock while in_stall is low: a tick or a
// bus-master event goes through the sequencer logic in the cycle it is accepted
// and its command is registered into a two-entry result buffer in front of the
// output channel, so input transactions keep flowing while one result waits;
// in_stall rises only when both entries are occupied.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no result is outstanding.
module humidity_sensor_i2c_poller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hsp_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output hsp_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [hsp_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [hsp_pkg::CfgDataWidth-1:0]   cfg_data
);

  hsp_pkg::cfg_t      cfg;
  hsp_pkg::out_item_t result;
  logic               accept;
  logic               buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  hsp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hsp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  hsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
